@@ sv/tte_pkg.sv @@
// Package with the types, codes and constants of the TCP timer expiry handler.
`timescale 1ns / 1ps
`default_nettype none
package tte_pkg;

   localparam int MAX_BACKOFF_SHIFT = 12;
   localparam int RTT_SCALE_SHIFT   = 3;
   localparam int MULT_LOG_CAP      = 6;
   localparam int LOSING_SHIFT      = MAX_BACKOFF_SHIFT / 4;

   localparam logic [1:0] OP_REXMT   = 2'd0;
   localparam logic [1:0] OP_PERSIST = 2'd1;
   localparam logic [1:0] OP_KEEP    = 2'd2;
   localparam logic [1:0] OP_2MSL    = 2'd3;

   localparam logic [2:0] ACT_REARM_2MSL = 3'd0;
   localparam logic [2:0] ACT_CLOSE      = 3'd1;
   localparam logic [2:0] ACT_DROP_TMO   = 3'd2;
   localparam logic [2:0] ACT_DROP_SOFT  = 3'd3;
   localparam logic [2:0] ACT_REXMT      = 3'd4;
   localparam logic [2:0] ACT_PERSIST    = 3'd5;
   localparam logic [2:0] ACT_KEEP_PROBE = 3'd6;
   localparam logic [2:0] ACT_KEEP_IDLE  = 3'd7;

   localparam logic [3:0] ST_ESTABLISHED = 4'd4;
   localparam logic [3:0] ST_CLOSE_WAIT  = 4'd5;
   localparam logic [3:0] ST_TIME_WAIT   = 4'd10;

   localparam logic [2:0] CSR_KEEP_IDLE     = 3'd0;
   localparam logic [2:0] CSR_KEEP_INTERVAL = 3'd1;
   localparam logic [2:0] CSR_KEEP_COUNT    = 3'd2;
   localparam logic [2:0] CSR_MAX_PERSIST   = 3'd3;
   localparam logic [2:0] CSR_MAX_RTO       = 3'd4;

   function automatic int backoff_total_f();
      int s;
      s = 0;
      for (int i = 0; i <= MAX_BACKOFF_SHIFT; i++) begin
         s = s + ((i < MULT_LOG_CAP) ? (1 << i) : (1 << MULT_LOG_CAP));
      end
      return s;
   endfunction

   localparam int BACKOFF_TOTAL = backoff_total_f();
   localparam int DIV_STEP      = 4;
   localparam int DIV_STAGES    = 8;
   localparam int W2_W          = 29;
   localparam int W2_PAD        = DIV_STEP * DIV_STAGES;

   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  st;
      logic [15:0] idle;
      logic [3:0]  shift;
      logic [15:0] srtt;
      logic [15:0] rttvar;
      logic [15:0] rmin;
      logic [29:0] cwnd;
      logic [15:0] mss;
      logic        keepon;
      logic        soft_err;
      logic [16:0] base;
      logic [26:0] pbase;
      logic [23:0] maxidle;
      logic [W2_W-1:0] w2;
   } pre_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] timer;
      logic [3:0]  nshift;
      logic [15:0] nrto;
      logic [15:0] nsrtt;
      logic [15:0] nvar;
      logic [29:0] ncwnd;
      logic        losing;
      logic        rx;
      logic [W2_W-1:0] w2;
      logic [15:0] mss;
      logic [15:0] rem;
   } res_type;

endpackage
`default_nettype wire

@@ sv/tcp_timer_expiry_handler.sv @@
// TCP timer expiry handler: decision pipeline with a staged remainder unit.
// Throughput: one transaction per cycle while the response side is not stalled;
// the eight remainder stages of the half-window by segment size division set the depth.
// Reset clears all valid bits and loads the configuration registers with their
// defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module tcp_timer_expiry_handler import tte_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // operation
   input  wire  [1:0]   req_tuser,
   // conn_state, idle_ticks, backoff_shift, smoothed_rtt, rtt_variance, min_rto,
   // send_window, congestion_window, max_segment, keepalive_on, soft_error_set
   input  wire  [151:0] req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // action
   output logic [2:0]   rsp_tuser,
   // timer_value, new_backoff_shift, new_rto, new_srtt, new_rttvar, new_cwnd,
   // new_ssthresh, losing
   output logic [135:0] rsp_tdata,
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [2:0]   csr_index,
   input  wire  [15:0]  csr_wdata
);

   logic [15:0] keep_idle_ff, keep_interval_ff, max_persist_ff, max_rto_ff;
   logic [7:0]  keep_count_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_idle_ff     <= 16'd14400;
         keep_interval_ff <= 16'd150;
         keep_count_ff    <= 8'd8;
         max_persist_ff   <= 16'd14400;
         max_rto_ff       <= 16'd128;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_KEEP_IDLE:     keep_idle_ff     <= csr_wdata;
            CSR_KEEP_INTERVAL: keep_interval_ff <= csr_wdata;
            CSR_KEEP_COUNT:    keep_count_ff    <= csr_wdata[7:0];
            CSR_MAX_PERSIST:   max_persist_ff   <= csr_wdata;
            CSR_MAX_RTO:       max_rto_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic en;
   logic out_v_ff;
   assign en         = !out_v_ff || rsp_tready;
   assign req_tready = en;

   // Stage 0: unpack, base terms and the probe limit product.
   pre_type pre_in, pre_ff;
   logic    pre_v_ff;
   logic [29:0] swnd_w, cwnd_w, wmin_w;

   always_comb begin
      swnd_w          = req_tdata[101:72];
      cwnd_w          = req_tdata[131:102];
      wmin_w          = (swnd_w < cwnd_w) ? swnd_w : cwnd_w;
      pre_in.op       = req_tuser;
      pre_in.st       = req_tdata[3:0];
      pre_in.idle     = req_tdata[19:4];
      pre_in.shift    = req_tdata[23:20];
      pre_in.srtt     = req_tdata[39:24];
      pre_in.rttvar   = req_tdata[55:40];
      pre_in.rmin     = req_tdata[71:56];
      pre_in.cwnd     = cwnd_w;
      pre_in.mss      = req_tdata[147:132];
      pre_in.keepon   = req_tdata[148];
      pre_in.soft_err = req_tdata[149];
      pre_in.base     = 17'(req_tdata[39:24] >> RTT_SCALE_SHIFT) + {1'b0, req_tdata[55:40]};
      pre_in.pbase    = 27'(pre_in.base) * 27'(BACKOFF_TOTAL);
      pre_in.maxidle  = {16'd0, keep_count_ff} * {8'd0, keep_interval_ff};
      pre_in.w2       = wmin_w[29:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_v_ff <= 1'b0;
      end else if (en) begin
         pre_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pre_ff <= pre_in;
      end
   end

   // Stage 1: timer decisions.
   res_type dec_in;
   logic [4:0]  s1_w;
   logic [2:0]  mlog_w;
   logic [22:0] rexmt_w;
   logic [16:0] var_sum_w;
   logic [24:0] keep_lim_w;

   always_comb begin
      s1_w       = {1'b0, pre_ff.shift} + 5'd1;
      mlog_w     = (s1_w < 5'(MULT_LOG_CAP)) ? s1_w[2:0] : 3'(MULT_LOG_CAP);
      rexmt_w    = 23'(pre_ff.base) << mlog_w;
      var_sum_w  = {1'b0, pre_ff.rttvar} + 17'(pre_ff.srtt >> RTT_SCALE_SHIFT);
      keep_lim_w = {9'd0, keep_idle_ff} + {1'b0, pre_ff.maxidle};
      dec_in.action = ACT_REARM_2MSL;
      dec_in.timer  = 16'd0;
      dec_in.nshift = pre_ff.shift;
      dec_in.nrto   = 16'd0;
      dec_in.nsrtt  = pre_ff.srtt;
      dec_in.nvar   = pre_ff.rttvar;
      dec_in.ncwnd  = pre_ff.cwnd;
      dec_in.losing = 1'b0;
      dec_in.rx     = 1'b0;
      dec_in.w2     = pre_ff.w2;
      dec_in.mss    = pre_ff.mss;
      dec_in.rem    = 16'd0;
      case (pre_ff.op)
         OP_REXMT: begin
            if (s1_w > 5'(MAX_BACKOFF_SHIFT)) begin
               dec_in.nshift = 4'(MAX_BACKOFF_SHIFT);
               dec_in.action = pre_ff.soft_err ? ACT_DROP_SOFT : ACT_DROP_TMO;
            end else begin
               if (rexmt_w < 23'(pre_ff.rmin)) begin
                  dec_in.nrto = pre_ff.rmin;
               end else if (rexmt_w > 23'(max_rto_ff)) begin
                  dec_in.nrto = max_rto_ff;
               end else begin
                  dec_in.nrto = rexmt_w[15:0];
               end
               dec_in.timer  = dec_in.nrto;
               dec_in.nshift = s1_w[3:0];
               dec_in.action = ACT_REXMT;
               dec_in.rx     = 1'b1;
               dec_in.ncwnd  = {14'd0, pre_ff.mss};
               if (s1_w > 5'(LOSING_SHIFT)) begin
                  dec_in.losing = 1'b1;
                  dec_in.nvar   = var_sum_w[16] ? 16'hFFFF : var_sum_w[15:0];
                  dec_in.nsrtt  = 16'd0;
               end
            end
         end
         OP_PERSIST: begin
            if (pre_ff.shift == 4'(MAX_BACKOFF_SHIFT) &&
                (pre_ff.idle >= max_persist_ff || 27'(pre_ff.idle) >= pre_ff.pbase)) begin
               dec_in.action = ACT_DROP_TMO;
            end else begin
               dec_in.action = ACT_PERSIST;
            end
         end
         OP_KEEP: begin
            if (pre_ff.st < ST_ESTABLISHED) begin
               dec_in.action = ACT_DROP_TMO;
            end else if (pre_ff.keepon && pre_ff.st <= ST_CLOSE_WAIT) begin
               if (25'(pre_ff.idle) >= keep_lim_w) begin
                  dec_in.action = ACT_DROP_TMO;
               end else begin
                  dec_in.action = ACT_KEEP_PROBE;
                  dec_in.timer  = keep_interval_ff;
               end
            end else begin
               dec_in.action = ACT_KEEP_IDLE;
               dec_in.timer  = keep_idle_ff;
            end
         end
         default: begin
            if (pre_ff.st != ST_TIME_WAIT && 24'(pre_ff.idle) <= pre_ff.maxidle) begin
               dec_in.action = ACT_REARM_2MSL;
               dec_in.timer  = keep_interval_ff;
            end else begin
               dec_in.action = ACT_CLOSE;
            end
         end
      endcase
   end

   // Stages 2 to 9: remainder of the half window by the segment size.
   res_type div_ff [DIV_STAGES+1];
   logic    div_v_ff [DIV_STAGES+1];

   function automatic logic [15:0] rem_step(input logic [15:0] r,
                                             input logic [DIV_STEP-1:0] b,
                                             input logic [15:0] d);
      logic [16:0] t;
      logic [15:0] c;
      c = r;
      for (int i = DIV_STEP - 1; i >= 0; i--) begin
         t = {c, b[i]};
         if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
         end
         c = t[15:0];
      end
      return c;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         div_v_ff[0] <= 1'b0;
      end else if (en) begin
         div_v_ff[0] <= pre_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff[0] <= dec_in;
      end
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      logic [W2_PAD-1:0] wpad_w;
      res_type           nxt_in;
      always_comb begin
         wpad_w     = W2_PAD'(div_ff[k].w2);
         nxt_in     = div_ff[k];
         nxt_in.rem = rem_step(div_ff[k].rem,
                               wpad_w[W2_PAD-1-DIV_STEP*k -: DIV_STEP], div_ff[k].mss);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            div_v_ff[k+1] <= 1'b0;
         end else if (en) begin
            div_v_ff[k+1] <= div_v_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            div_ff[k+1] <= nxt_in;
         end
      end
   end

   // Stage 10: slow start threshold and output register.
   res_type     fin_w;
   logic [16:0] two_mss_w;
   logic [29:0] ssth_in, ssth_ff;
   res_type     out_ff;

   always_comb begin
      fin_w     = div_ff[DIV_STAGES];
      two_mss_w = {fin_w.mss, 1'b0};
      if (!fin_w.rx || fin_w.mss == 16'd0) begin
         ssth_in = 30'd0;
      end else if (fin_w.w2 < 29'(two_mss_w)) begin
         ssth_in = 30'(two_mss_w);
      end else begin
         ssth_in = 30'(fin_w.w2 - 29'(fin_w.rem));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= div_v_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff  <= fin_w;
         ssth_ff <= ssth_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_ff.action;
   assign rsp_tdata  = {7'd0, out_ff.losing, ssth_ff, out_ff.ncwnd, out_ff.nvar,
                        out_ff.nsrtt, out_ff.nrto, out_ff.nshift, out_ff.timer};

`ifndef SYNTH
   a_rexmt_timer: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ACT_REXMT |-> rsp_tdata[15:0] == rsp_tdata[35:20])
      else $error("retransmit timer differs from new rto");
   a_side_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ACT_REXMT |-> rsp_tdata[128:98] == 31'd0
      && rsp_tdata[35:20] == 16'd0)
      else $error("retransmit-only fields set on another action");
   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ACT_REXMT |-> rsp_tdata[19:16] <= 4'(MAX_BACKOFF_SHIFT))
      else $error("backoff exponent beyond maximum");
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");
`endif

endmodule
`default_nettype wire

@@ test/tte_checker.sv @@
// Checker for the TCP timer expiry handler: predicts each response and compares it.
`timescale 1ns / 1ps
module tte_checker import tte_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   input  wire          req_tready,
   input  wire  [1:0]   req_tuser,
   input  wire  [151:0] req_tdata,
   input  wire          rsp_tvalid,
   input  wire          rsp_tready,
   input  wire  [2:0]   rsp_tuser,
   input  wire  [135:0] rsp_tdata,
   input  wire          csr_valid,
   input  wire          csr_ready,
   input  wire  [2:0]   csr_index,
   input  wire  [15:0]  csr_wdata,
   output int           fail_count,
   output int           pending
);

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] timer;
      logic [3:0]  nshift;
      logic [15:0] nrto;
      logic [15:0] nsrtt;
      logic [15:0] nvar;
      logic [29:0] ncwnd;
      logic [29:0] nssth;
      logic        losing;
   } expiry_result_t;

   logic [15:0] cfg_keep_idle;
   logic [15:0] cfg_keep_interval;
   logic [7:0]  cfg_keep_count;
   logic [15:0] cfg_max_persist;
   logic [15:0] cfg_max_rto;

   expiry_result_t expected_responses[$];

   function automatic logic [63:0] mult_of(logic [63:0] i);
      return (i < 6) ? (64'd1 << i) : 64'd64;
   endfunction

   function automatic logic [63:0] mult_sum();
      logic [63:0] s;
      s = 0;
      for (int i = 0; i <= MAX_BACKOFF_SHIFT; i++) s = s + mult_of(i);
      return s;
   endfunction

   function automatic expiry_result_t decide_expiry(logic [1:0] op, logic [151:0] d);
      expiry_result_t r;
      logic [63:0] st, idle, shift, srtt, rttvar, rmin, swnd, cwnd, mss;
      logic [63:0] base, maxidle, s1, rexmt, w, q, nv, ss;
      logic keepon, soft_err;
      st = d[3:0];       idle = d[19:4];     shift = d[23:20];
      srtt = d[39:24];   rttvar = d[55:40];  rmin = d[71:56];
      swnd = d[101:72];  cwnd = d[131:102];  mss = d[147:132];
      keepon = d[148];   soft_err = d[149];
      base = (srtt >> RTT_SCALE_SHIFT) + rttvar;
      maxidle = 64'(cfg_keep_count) * 64'(cfg_keep_interval);
      r = '0;
      r.nshift = shift[3:0];
      r.nsrtt = srtt[15:0];
      r.nvar = rttvar[15:0];
      r.ncwnd = cwnd[29:0];
      case (op)
         OP_REXMT: begin
            s1 = shift + 1;
            if (s1 > MAX_BACKOFF_SHIFT) begin
               r.nshift = 4'(MAX_BACKOFF_SHIFT);
               r.action = soft_err ? ACT_DROP_SOFT : ACT_DROP_TMO;
            end else begin
               rexmt = base * mult_of(s1);
               if (rexmt < rmin) r.nrto = rmin[15:0];
               else if (rexmt > cfg_max_rto) r.nrto = cfg_max_rto;
               else r.nrto = rexmt[15:0];
               r.nshift = s1[3:0];
               r.timer = r.nrto;
               r.action = ACT_REXMT;
               if (s1 > LOSING_SHIFT) begin
                  r.losing = 1'b1;
                  nv = rttvar + (srtt >> RTT_SCALE_SHIFT);
                  r.nvar = (nv > 64'hFFFF) ? 16'hFFFF : nv[15:0];
                  r.nsrtt = 16'd0;
               end
               w = (swnd < cwnd) ? swnd : cwnd;
               q = (mss != 0) ? (w / 2) / mss : 0;
               if (q < 2) q = 2;
               r.ncwnd = mss[29:0];
               ss = q * mss;
               r.nssth = (ss > 64'h3FFFFFFF) ? 30'h3FFFFFFF : ss[29:0];
            end
         end
         OP_PERSIST: begin
            if (shift == MAX_BACKOFF_SHIFT &&
                (idle >= cfg_max_persist || idle >= base * mult_sum()))
               r.action = ACT_DROP_TMO;
            else
               r.action = ACT_PERSIST;
         end
         OP_KEEP: begin
            if (st < ST_ESTABLISHED) begin
               r.action = ACT_DROP_TMO;
            end else if (keepon && st <= ST_CLOSE_WAIT) begin
               if (idle >= 64'(cfg_keep_idle) + maxidle) begin
                  r.action = ACT_DROP_TMO;
               end else begin
                  r.action = ACT_KEEP_PROBE;
                  r.timer = cfg_keep_interval;
               end
            end else begin
               r.action = ACT_KEEP_IDLE;
               r.timer = cfg_keep_idle;
            end
         end
         default: begin
            if (st != ST_TIME_WAIT && idle <= maxidle) begin
               r.action = ACT_REARM_2MSL;
               r.timer = cfg_keep_interval;
            end else begin
               r.action = ACT_CLOSE;
            end
         end
      endcase
      return r;
   endfunction

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      expiry_result_t e;
      if (reset) begin
         cfg_keep_idle <= 16'd14400;
         cfg_keep_interval <= 16'd150;
         cfg_keep_count <= 8'd8;
         cfg_max_persist <= 16'd14400;
         cfg_max_rto <= 16'd128;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KEEP_IDLE:     cfg_keep_idle <= csr_wdata;
               CSR_KEEP_INTERVAL: cfg_keep_interval <= csr_wdata;
               CSR_KEEP_COUNT:    cfg_keep_count <= csr_wdata[7:0];
               CSR_MAX_PERSIST:   cfg_max_persist <= csr_wdata;
               CSR_MAX_RTO:       cfg_max_rto <= csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) expected_responses.push_back(decide_expiry(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_responses.size() == 0) begin
               $display("%0t ns: unexpected response, expected none, actual %0h %0h",
                        $time, rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               e = expected_responses.pop_front();
               check_field("action", e.action, rsp_tuser);
               check_field("timer_value", e.timer, rsp_tdata[15:0]);
               check_field("new_backoff_shift", e.nshift, rsp_tdata[19:16]);
               check_field("new_rto", e.nrto, rsp_tdata[35:20]);
               check_field("new_srtt", e.nsrtt, rsp_tdata[51:36]);
               check_field("new_rttvar", e.nvar, rsp_tdata[67:52]);
               check_field("new_cwnd", e.ncwnd, rsp_tdata[97:68]);
               check_field("new_ssthresh", e.nssth, rsp_tdata[127:98]);
               check_field("losing", e.losing, rsp_tdata[128]);
               check_field("padding", 0, rsp_tdata[135:129]);
            end
         end
      end
      pending <= expected_responses.size();
   end

endmodule

@@ test/tb.sv @@
// Testbench top for the TCP timer expiry handler: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb;
   import tte_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [1:0]   req_tuser = '0;
   logic [151:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [2:0]   rsp_tuser;
   logic [135:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [15:0]  csr_wdata = '0;
   int           fail_count;
   int           pending;
   int           cycle_count = 0;
   int           stall_mode = 0;
   int           burst_left = 0;

   always #2 clock = ~clock;

   tcp_timer_expiry_handler DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   tte_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= $urandom_range(0, 1);
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (cycle_count % 7) < 4;
      endcase
   end

   function automatic logic [151:0] pack_event(logic [3:0] st, logic [15:0] idle,
         logic [3:0] shift, logic [15:0] srtt, logic [15:0] rttvar, logic [15:0] rmin,
         logic [29:0] swnd, logic [29:0] cwnd, logic [15:0] mss, logic keepon,
         logic soft_err);
      return {2'b00, soft_err, keepon, mss, cwnd, swnd, rmin, rttvar, srtt, shift, idle, st};
   endfunction

   task automatic send_event(logic [1:0] op, logic [151:0] d);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return $urandom_range(0, 40);
         3: return $urandom_range(100, 20000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [29:0] pick30();
      case ($urandom_range(0, 4))
         0: return 30'd0;
         1: return 30'h3FFFFFFF;
         2: return $urandom_range(0, 200000);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_event();
      logic [1:0] op;
      logic [3:0] st, shift;
      logic [15:0] idle, mss;
      op = $urandom_range(0, 3);
      st = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(3, 10);
      shift = ($urandom_range(0, 2) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 15);
      idle = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 2000) : pick16();
      mss = ($urandom_range(0, 9) == 0) ? 16'd0 : pick16();
      send_event(op, pack_event(st, idle, shift, pick16(), pick16(), pick16(),
                 pick30(), pick30(), mss, $urandom_range(0, 1), $urandom_range(0, 1)));
   endtask

   task automatic set_limits(logic [15:0] ki, logic [15:0] kv, logic [15:0] kc,
                             logic [15:0] mp, logic [15:0] mr);
      write_csr(CSR_KEEP_IDLE, ki);
      write_csr(CSR_KEEP_INTERVAL, kv);
      write_csr(CSR_KEEP_COUNT, kc);
      write_csr(CSR_MAX_PERSIST, mp);
      write_csr(CSR_MAX_RTO, mr);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed events under the reset limits.
      send_event(OP_REXMT, pack_event(4, 0, 0, 80, 3, 1, 5000, 9000, 1460, 0, 0));
      send_event(OP_REXMT, pack_event(4, 0, 2, 16, 1, 1, 5000, 9000, 1460, 0, 0));
      send_event(OP_REXMT, pack_event(4, 0, 3, 16, 1, 1, 5000, 9000, 1460, 0, 0));
      send_event(OP_REXMT, pack_event(4, 0, 11, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 30'h3FFFFFFF, 30'h3FFFFFFF, 1, 1, 1));
      send_event(OP_REXMT, pack_event(4, 0, 12, 8, 8, 1, 100, 100, 10, 0, 0));
      send_event(OP_REXMT, pack_event(4, 0, 12, 8, 8, 1, 100, 100, 10, 0, 1));
      send_event(OP_REXMT, pack_event(15, 16'hFFFF, 15, 8, 8, 1, 100, 100, 10, 1, 1));
      send_event(OP_REXMT, pack_event(4, 0, 1, 8, 8, 0, 100, 100, 0, 0, 0));
      send_event(OP_REXMT, pack_event(4, 0, 1, 8, 8, 1000, 1, 0, 16'hFFFF, 0, 0));
      send_event(OP_PERSIST, pack_event(4, 16'hFFFF, 12, 8, 1, 1, 0, 0, 1, 0, 0));
      send_event(OP_PERSIST, pack_event(4, 600, 12, 8, 1, 1, 0, 0, 1, 0, 0));
      send_event(OP_PERSIST, pack_event(4, 16'hFFFF, 13, 8, 1, 1, 0, 0, 1, 0, 0));
      send_event(OP_PERSIST, pack_event(4, 0, 0, 0, 0, 1, 0, 0, 1, 0, 0));
      send_event(OP_KEEP, pack_event(3, 0, 0, 0, 0, 1, 0, 0, 1, 1, 0));
      send_event(OP_KEEP, pack_event(4, 15599, 0, 0, 0, 1, 0, 0, 1, 1, 0));
      send_event(OP_KEEP, pack_event(5, 15600, 0, 0, 0, 1, 0, 0, 1, 1, 0));
      send_event(OP_KEEP, pack_event(6, 0, 0, 0, 0, 1, 0, 0, 1, 1, 0));
      send_event(OP_KEEP, pack_event(4, 0, 0, 0, 0, 1, 0, 0, 1, 0, 0));
      send_event(OP_2MSL, pack_event(4, 1200, 0, 0, 0, 1, 0, 0, 1, 0, 0));
      send_event(OP_2MSL, pack_event(4, 1201, 0, 0, 0, 1, 0, 0, 1, 0, 0));
      send_event(OP_2MSL, pack_event(10, 0, 0, 0, 0, 1, 0, 0, 1, 0, 0));
      send_event(OP_2MSL, pack_event(15, 16'hFFFF, 0, 0, 0, 1, 0, 0, 1, 0, 0));
      repeat (200) send_random_event();
      drain_pipeline();

      set_limits(1, 1, 1, 1, 1);
      repeat (200) send_random_event();
      drain_pipeline();

      set_limits(16'hFFFF, 16'hFFFF, 255, 16'hFFFF, 16'hFFFF);
      repeat (200) send_random_event();
      drain_pipeline();

      set_limits(0, 0, 0, 0, 0);
      repeat (150) send_random_event();
      drain_pipeline();

      for (int p = 0; p < 3; p++) begin
         set_limits($urandom_range(1, 3000), $urandom_range(1, 300), $urandom_range(1, 255),
                    $urandom_range(1, 5000), $urandom_range(1, 2000));
         repeat (150) send_random_event();
         drain_pipeline();
      end

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
